### rtl/rffa_pkg.sv
// Shared types, constants and helpers for the next-fit allocator.
// Used by rffa_cell, rffa_ctrl and rover_first_fit_allocator_top. No dependencies.
package rffa_pkg;

    localparam int SIZE_W         = 23;
    localparam int ADDR_W         = 22;
    localparam int TAG_W          = 16;
    localparam int HEADER_BYTES   = 24;
    localparam int MIN_FRAGMENT   = 64;
    localparam int DEF_MAX_BLOCKS = 64;

    localparam logic [SIZE_W-1:0] ZONE_RESET = 23'h200000;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_SPACE     = 3'd1,
        ST_ZERO_TAG     = 3'd2,
        ST_NULL_PTR     = 3'd3,
        ST_NOT_START    = 3'd4,
        ST_ALREADY_FREE = 3'd5
    } t_status;

    // One block of the arena; sentinel closes the ring, rov/tgt mark rover and free target
    typedef struct packed {
        logic              valid;
        logic              sent;
        logic              rov;
        logic              tgt;
        logic [SIZE_W-1:0] offset;
        logic [SIZE_W-1:0] bytes;
        logic [TAG_W-1:0]  owner;
    } t_blk;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROT,
        OP_DEL_HEAD,
        OP_DEL_SECOND,
        OP_SPLIT,
        OP_GRANT,
        OP_CLR_OWNER,
        OP_LOAD
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              mark;
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W:0]   need;
        logic [SIZE_W-1:0] zone;
    } t_cmd;

    // What the sequencer sees of the chain
    typedef struct packed {
        t_blk head;
        t_blk second;
        logic full;
        logic last_free;
    } t_view;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [SIZE_W-1:0] offset);
        logic [SIZE_W:0] s;
        s = {1'b0, offset} + (SIZE_W+1)'(HEADER_BYTES);
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic owned(input t_blk b);
        return b.sent || (b.owner != '0);
    endfunction

    function automatic t_blk load_blk(input logic is_head, input logic is_second,
                                      input logic [SIZE_W-1:0] zone);
        t_blk b;
        b = '0;
        if (is_head) begin
            b.valid = 1'b1;
            b.rov   = 1'b1;
            b.bytes = zone;
        end else if (is_second) begin
            b.valid = 1'b1;
            b.sent  = 1'b1;
        end
        return b;
    endfunction

endpackage

### rtl/rffa_cell.sv
// One cell of the block ring: holds one block record, shifts to/from its neighbors.
// Depends on rffa_pkg.
module rffa_cell import rffa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  logic  i_is_head,
    input  logic  i_is_second,
    input  t_blk  i_head,
    input  t_blk  i_left,
    input  t_blk  i_right,
    input  logic  i_rr_valid,
    output t_blk  o_blk,
    output logic  o_last_free
);

    t_blk r_blk;
    t_blk n_blk;

    always_comb begin
        n_blk = r_blk;
        case (i_cmd.op)
            OP_ROT: begin
                if (r_blk.valid) begin
                    // last cell of the ring wraps the head around
                    n_blk = i_right.valid ? i_right : i_head;
                    if (i_cmd.mark) n_blk.tgt = !i_right.valid;
                end
            end
            OP_DEL_HEAD: begin
                n_blk = i_right;
                if (r_blk.valid && i_right.valid && !i_rr_valid) begin
                    n_blk.bytes = i_right.bytes + i_head.bytes;
                    n_blk.rov   = i_right.rov | i_head.rov;
                end
            end
            OP_DEL_SECOND: begin
                if (i_is_head) begin
                    n_blk.bytes = r_blk.bytes + i_right.bytes;
                    n_blk.rov   = r_blk.rov | i_right.rov;
                end else begin
                    n_blk = i_right;
                end
            end
            OP_SPLIT: begin
                if (i_is_head) begin
                    n_blk.owner = i_cmd.tag;
                    n_blk.bytes = i_cmd.need[SIZE_W-1:0];
                    n_blk.rov   = 1'b0;
                end else if (i_is_second) begin
                    n_blk        = '0;
                    n_blk.valid  = 1'b1;
                    n_blk.rov    = 1'b1;
                    n_blk.offset = i_head.offset + i_cmd.need[SIZE_W-1:0];
                    n_blk.bytes  = i_head.bytes - i_cmd.need[SIZE_W-1:0];
                end else begin
                    n_blk     = i_left;
                    n_blk.rov = 1'b0;
                end
            end
            OP_GRANT: begin
                n_blk.rov = i_is_second;
                if (i_is_head) n_blk.owner = i_cmd.tag;
            end
            OP_CLR_OWNER: begin
                if (i_is_head) n_blk.owner = '0;
            end
            OP_LOAD: n_blk = load_blk(i_is_head, i_is_second, i_cmd.zone);
            default: n_blk = r_blk;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk <= load_blk(i_is_head, i_is_second, ZONE_RESET);
        end else begin
            r_blk <= n_blk;
        end
    end

    assign o_blk       = r_blk;
    assign o_last_free = r_blk.valid && !i_right.valid && !owned(r_blk);

endmodule

### rtl/rffa_ctrl.sv
// Sequencer: scan, lookup, merge and restore steps over the cell ring, plus result register.
// Depends on rffa_pkg.
module rffa_ctrl import rffa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [SIZE_W-1:0] i_request_bytes,
    input  logic [TAG_W-1:0]  i_owner_tag,
    input  logic [ADDR_W-1:0] i_data_address,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_status,
    output logic [ADDR_W-1:0] o_granted_address,
    output logic [SIZE_W-1:0] o_granted_bytes,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  t_view             i_view,
    output t_cmd              o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SCAN = 9'b000000010,
        S_LOOK = 9'b000000100,
        S_FIND = 9'b000001000,
        S_CHK  = 9'b000010000,
        S_MRGP = 9'b000100000,
        S_MRGN = 9'b001000000,
        S_REST = 9'b010000000,
        S_RESP = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [SIZE_W:0]   r_need, n_need;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_prev_own, n_prev_own;
    logic              r_first, n_first;
    logic              r_have, n_have;
    logic              r_after, n_after;
    logic              r_passed, n_passed;
    logic              r_mode, n_mode;
    t_status           r_res_status, n_res_status;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic [SIZE_W-1:0] r_res_bytes, n_res_bytes;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    logic [SIZE_W-1:0] r_out_bytes, n_out_bytes;

    logic              w_fits, w_split, w_hit, w_take;
    logic [SIZE_W-1:0] w_extra;
    logic [SIZE_W:0]   w_sum;

    always_comb begin
        w_sum   = {1'b0, i_request_bytes} + (SIZE_W+1)'(HEADER_BYTES + 11);
        w_fits  = !owned(i_view.head) && ({1'b0, i_view.head.bytes} >= r_need);
        w_extra = i_view.head.bytes - r_need[SIZE_W-1:0];
        w_split = (w_extra > SIZE_W'(MIN_FRAGMENT)) && !i_view.full;
        w_hit   = !i_view.head.sent && (addr_of(i_view.head.offset) == r_addr);
        w_take  = w_hit && (!r_have || (r_passed && !r_after));
    end

    always_comb begin
        n_state      = r_state;
        n_need       = r_need;
        n_tag        = r_tag;
        n_addr       = r_addr;
        n_prev_own   = r_prev_own;
        n_first      = r_first;
        n_have       = r_have;
        n_after      = r_after;
        n_passed     = r_passed;
        n_mode       = r_mode;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_res_bytes  = r_res_bytes;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        n_out_bytes  = r_out_bytes;
        o_cmd.op     = OP_HOLD;
        o_cmd.mark   = 1'b0;
        o_cmd.tag    = r_tag;
        o_cmd.need   = r_need;
        o_cmd.zone   = i_cfg_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_status = ST_OK;
                    n_res_addr   = '0;
                    n_res_bytes  = '0;
                    if (i_req_type == REQ_ALLOC) begin
                        if (i_owner_tag == '0) begin
                            n_res_status = ST_ZERO_TAG;
                            n_state      = S_RESP;
                        end else begin
                            n_need     = {w_sum[SIZE_W:3], 3'b000};
                            n_tag      = i_owner_tag;
                            n_prev_own = 1'b0;
                            n_first    = 1'b1;
                            n_state    = S_SCAN;
                        end
                    end else if (i_data_address == '0) begin
                        n_res_status = ST_NULL_PTR;
                        n_state      = S_RESP;
                    end else begin
                        n_addr   = i_data_address;
                        n_have   = 1'b0;
                        n_after  = 1'b0;
                        n_passed = 1'b0;
                        n_state  = S_LOOK;
                    end
                end
            end
            S_SCAN: begin
                // base is tested only right after an owned block, or at the rover
                if ((r_prev_own || r_first) && w_fits) begin
                    o_cmd.op     = w_split ? OP_SPLIT : OP_GRANT;
                    n_res_addr   = addr_of(i_view.head.offset);
                    n_res_bytes  = w_split ? r_need[SIZE_W-1:0] : i_view.head.bytes;
                    n_state      = S_REST;
                end else if (i_view.second.rov) begin
                    n_res_status = ST_NO_SPACE;
                    n_state      = S_REST;
                end else begin
                    o_cmd.op   = OP_ROT;
                    n_prev_own = owned(i_view.head);
                    n_first    = 1'b0;
                end
            end
            S_LOOK: begin
                // one lap; the first match past the sentinel wins over earlier ones
                o_cmd.op   = OP_ROT;
                o_cmd.mark = w_take;
                if (w_take) begin
                    n_have  = 1'b1;
                    n_after = r_passed;
                end
                if (i_view.head.sent) n_passed = 1'b1;
                if (i_view.second.rov) begin
                    if (r_have || w_take) begin
                        n_state = S_FIND;
                    end else begin
                        n_res_status = ST_NOT_START;
                        n_state      = S_RESP;
                    end
                end
            end
            S_FIND: begin
                if (i_view.head.tgt) n_state = S_CHK;
                else                 o_cmd.op = OP_ROT;
            end
            S_CHK: begin
                if (i_view.head.owner == '0) begin
                    n_res_status = ST_ALREADY_FREE;
                    n_state      = S_REST;
                end else begin
                    o_cmd.op = OP_CLR_OWNER;
                    n_state  = S_MRGP;
                end
            end
            S_MRGP: begin
                n_mode = i_view.last_free;
                if (i_view.last_free) o_cmd.op = OP_DEL_HEAD;
                n_state = S_MRGN;
            end
            S_MRGN: begin
                // freed block sits at the ring tail after a merge with its predecessor
                if (r_mode) begin
                    if (!owned(i_view.head)) o_cmd.op = OP_DEL_HEAD;
                end else if (!owned(i_view.second)) begin
                    o_cmd.op = OP_DEL_SECOND;
                end
                n_state = S_REST;
            end
            S_REST: begin
                if (i_view.head.rov) n_state = S_RESP;
                else                 o_cmd.op = OP_ROT;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_addr   = r_res_addr;
                    n_out_bytes  = r_res_bytes;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_we) o_cmd.op = OP_LOAD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_need       <= n_need;
        r_tag        <= n_tag;
        r_addr       <= n_addr;
        r_prev_own   <= n_prev_own;
        r_first      <= n_first;
        r_have       <= n_have;
        r_after      <= n_after;
        r_passed     <= n_passed;
        r_mode       <= n_mode;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_res_bytes  <= n_res_bytes;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
        r_out_bytes  <= n_out_bytes;
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_granted_address = r_out_addr;
    assign o_granted_bytes   = r_out_bytes;

endmodule

### rtl/rover_first_fit_allocator_top.sv
// Next-fit allocator with coalescing: ring of block cells plus sequencer.
// Depends on rffa_pkg, rffa_cell and rffa_ctrl.
//
// Usage: requests enter on i_in_valid/o_in_ready (allocate or free), one result
// transaction leaves on o_out_valid/i_out_ready per request. The arena is kept as
// a ring of MAX_BLOCKS+1 cells in address order (sentinel included), rotated one
// step per cycle while searching; the block under test always sits in the head cell.
// Sequence from acceptance to o_out_valid: tag or null-pointer errors go straight
// to the response step. An allocate makes one rotation per block scanned from the
// rover, then one step onto the new rover. A free makes one full lap for address
// lookup, rotates to the block, checks it, merges with a free predecessor and a
// free successor, then rotates back to the rover. Only one request is in work at
// a time; the ring rotation sets the rate, and the next request is taken once the
// result is registered.
// A finished result sits in the output register; the next request is accepted
// while it waits, and its own result waits until the register frees up.
// Reset (i_rst_n low, synchronous) and any i_cfg_we write load the arena as one
// free block of zone_bytes (2097152 after reset) with the rover on it; no
// clearing pass is needed. Write zone_bytes only while the block is idle.
module rover_first_fit_allocator_top import rffa_pkg::*; #(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [SIZE_W-1:0] i_request_bytes,
    input  logic [TAG_W-1:0]  i_owner_tag,
    input  logic [ADDR_W-1:0] i_data_address,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_status,
    output logic [ADDR_W-1:0] o_granted_address,
    output logic [SIZE_W-1:0] o_granted_bytes,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    localparam int NCELL = MAX_BLOCKS + 1;

    t_cmd              w_cmd;
    t_view             w_view;
    t_blk              w_blk   [NCELL];
    t_blk              w_left  [NCELL];
    t_blk              w_right [NCELL];
    logic [NCELL-1:0]  w_rr_valid;
    logic [NCELL-1:0]  w_last_free;
    logic [NCELL-1:0]  w_rov_vec;
    logic [NCELL-1:0]  w_sent_vec;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        if (k == 0) begin : g_l0
            assign w_left[k] = '0;
        end else begin : g_ln
            assign w_left[k] = w_blk[k-1];
        end
        if (k < NCELL - 1) begin : g_rn
            assign w_right[k] = w_blk[k+1];
        end else begin : g_r0
            assign w_right[k] = '0;
        end
        if (k < NCELL - 2) begin : g_rrn
            assign w_rr_valid[k] = w_blk[k+2].valid;
        end else begin : g_rr0
            assign w_rr_valid[k] = 1'b0;
        end

        rffa_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_is_head   (k == 0),
            .i_is_second (k == 1),
            .i_head      (w_blk[0]),
            .i_left      (w_left[k]),
            .i_right     (w_right[k]),
            .i_rr_valid  (w_rr_valid[k]),
            .o_blk       (w_blk[k]),
            .o_last_free (w_last_free[k])
        );

        assign w_rov_vec[k]  = w_blk[k].valid && w_blk[k].rov;
        assign w_sent_vec[k] = w_blk[k].valid && w_blk[k].sent;
    end

    assign w_view.head      = w_blk[0];
    assign w_view.second    = w_blk[1];
    assign w_view.full      = w_blk[NCELL-1].valid;
    assign w_view.last_free = |w_last_free;

    rffa_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_request_bytes   (i_request_bytes),
        .i_owner_tag       (i_owner_tag),
        .i_data_address    (i_data_address),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_granted_bytes   (o_granted_bytes),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_view            (w_view),
        .o_cmd             (w_cmd)
    );

`ifndef SYNTHESIS
    a_ring_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_blk[0].valid && w_blk[1].valid)
        else $error("ring shorter than a block plus sentinel");

    a_one_rover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_rov_vec))
        else $error("rover mark lost or duplicated");

    a_one_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_sent_vec))
        else $error("sentinel lost or duplicated");

    a_idle_rover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> w_blk[0].rov)
        else $error("idle with rover away from head cell");
`endif

endmodule
